>>> design/csl_pkg.sv
// Shared constants, command codes and control types of the curvature speed limit block.
package csl_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int CFG_W           = 24;
    localparam int ARC_W           = 32;
    localparam int DATA_W          = 32;
    localparam int ADDR_W          = 4;
    localparam int RATIO_W         = CFG_W + 32;
    localparam int CURV_ITERS      = 33;

    localparam logic [CFG_W-1:0] THR_RST = 24'd10637;
    localparam logic [CFG_W-1:0] TOP_RST = 24'd363725;
    localparam logic [CFG_W-1:0] LAT_RST = 24'd32768;
    localparam logic [CFG_W-1:0] CFG_MAX = '1;

    localparam logic [1:0] REG_THR = 2'd0;
    localparam logic [1:0] REG_TOP = 2'd1;
    localparam logic [1:0] REG_LAT = 2'd2;

    typedef logic [4:0] op_t;

    localparam op_t OP_IDLE   = 5'd0;
    localparam op_t OP_LOAD   = 5'd1;
    localparam op_t OP_SQ_BX  = 5'd2;
    localparam op_t OP_SQ_BY  = 5'd3;
    localparam op_t OP_RT_B   = 5'd4;
    localparam op_t OP_CR1    = 5'd5;
    localparam op_t OP_CR2    = 5'd6;
    localparam op_t OP_SQ_CX  = 5'd7;
    localparam op_t OP_SQ_CY  = 5'd8;
    localparam op_t OP_RT_C   = 5'd9;
    localparam op_t OP_MUL_AB = 5'd10;
    localparam op_t OP_MUL_D  = 5'd11;
    localparam op_t OP_DIV_C  = 5'd12;
    localparam op_t OP_SAT    = 5'd13;
    localparam op_t OP_TOP    = 5'd14;
    localparam op_t OP_DIV_S  = 5'd15;
    localparam op_t OP_RT_S   = 5'd16;
    localparam op_t OP_EMIT   = 5'd17;
    localparam op_t OP_COMMIT = 5'd18;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic done;
        logic restart;
        logic seen2;
        logic degen;
        logic cr_zero;
        logic cr_ge_d;
        logic curv_le_thr;
        logic out_free;
    } status_t;

    function automatic logic is_iter(input op_t op);
        case (op) inside
            OP_SQ_BX, OP_SQ_BY, OP_RT_B, OP_CR1, OP_CR2, OP_SQ_CX, OP_SQ_CY,
            OP_RT_C, OP_MUL_AB, OP_MUL_D, OP_DIV_C, OP_DIV_S, OP_RT_S: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

endpackage

>>> design/csl_if.sv
// Point and result channel interfaces.
interface csl_point_if #(parameter int COORD_WIDTH = csl_pkg::COORD_WIDTH_DEF);
    logic                          valid;
    logic                          ready;
    logic                          path_start;
    logic signed [COORD_WIDTH-1:0] pos_x;
    logic signed [COORD_WIDTH-1:0] pos_y;

    modport source (output valid, path_start, pos_x, pos_y, input ready);
    modport sink   (input valid, path_start, pos_x, pos_y, output ready);
endinterface

interface csl_result_if;
    logic                         valid;
    logic                         ready;
    logic [csl_pkg::CFG_W-1:0]    curvature;
    logic [csl_pkg::CFG_W-1:0]    speed_limit;
    logic [csl_pkg::ARC_W-1:0]    arc_length;
    logic                         degenerate;

    modport source (output valid, curvature, speed_limit, arc_length, degenerate, input ready);
    modport sink   (input valid, curvature, speed_limit, arc_length, degenerate, output ready);
endinterface

>>> design/csl_regs.sv
// APB configuration registers: threshold, top speed and lateral acceleration.
module csl_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [csl_pkg::ADDR_W-1:0]  paddr,
    input  logic [csl_pkg::DATA_W-1:0]  pwdata,
    output logic [csl_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output logic [csl_pkg::CFG_W-1:0]   thr,
    output logic [csl_pkg::CFG_W-1:0]   top,
    output logic [csl_pkg::CFG_W-1:0]   lat
);

    logic [csl_pkg::CFG_W-1:0] thr_reg, top_reg, lat_reg;
    logic [1:0]                idx;
    logic                      wr;

    assign idx    = paddr[3:2];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= csl_pkg::THR_RST;
            top_reg <= csl_pkg::TOP_RST;
            lat_reg <= csl_pkg::LAT_RST;
        end
        else if (wr)
        begin
            unique case (idx)
                csl_pkg::REG_THR: thr_reg <= pwdata[csl_pkg::CFG_W-1:0];
                csl_pkg::REG_TOP: top_reg <= pwdata[csl_pkg::CFG_W-1:0];
                csl_pkg::REG_LAT: lat_reg <= pwdata[csl_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            csl_pkg::REG_THR: prdata = csl_pkg::DATA_W'(thr_reg);
            csl_pkg::REG_TOP: prdata = csl_pkg::DATA_W'(top_reg);
            csl_pkg::REG_LAT: prdata = csl_pkg::DATA_W'(lat_reg);
            default:          prdata = '0;
        endcase
    end

    assign thr = thr_reg;
    assign top = top_reg;
    assign lat = lat_reg;

endmodule

>>> design/csl_ctrl.sv
// Sequencing state machine: steps the datapath through one point's computation.
module csl_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  csl_pkg::status_t  stat,
    output csl_pkg::cmd_t     cmd
);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_SQBX   = 5'd1;
    localparam logic [4:0] S_SQBY   = 5'd2;
    localparam logic [4:0] S_RTB    = 5'd3;
    localparam logic [4:0] S_CR1    = 5'd4;
    localparam logic [4:0] S_CR2    = 5'd5;
    localparam logic [4:0] S_CRCHK  = 5'd6;
    localparam logic [4:0] S_SQCX   = 5'd7;
    localparam logic [4:0] S_SQCY   = 5'd8;
    localparam logic [4:0] S_RTC    = 5'd9;
    localparam logic [4:0] S_AB     = 5'd10;
    localparam logic [4:0] S_D      = 5'd11;
    localparam logic [4:0] S_DCHK   = 5'd12;
    localparam logic [4:0] S_DIVC   = 5'd13;
    localparam logic [4:0] S_SAT    = 5'd14;
    localparam logic [4:0] S_CHK    = 5'd15;
    localparam logic [4:0] S_TOP    = 5'd16;
    localparam logic [4:0] S_DIVS   = 5'd17;
    localparam logic [4:0] S_RTS    = 5'd18;
    localparam logic [4:0] S_OUT    = 5'd19;
    localparam logic [4:0] S_COMMIT = 5'd20;

    logic [4:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = csl_pkg::OP_IDLE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op = csl_pkg::OP_LOAD;
                    if (!stat.restart)
                        state_next = S_SQBX;
                end
            end
            S_SQBX:
            begin
                cmd.op = csl_pkg::OP_SQ_BX;
                if (stat.done) state_next = S_SQBY;
            end
            S_SQBY:
            begin
                cmd.op = csl_pkg::OP_SQ_BY;
                if (stat.done) state_next = S_RTB;
            end
            S_RTB:
            begin
                cmd.op = csl_pkg::OP_RT_B;
                if (stat.done)
                begin
                    if (!stat.seen2)
                        state_next = S_COMMIT;
                    else if (stat.degen)
                        state_next = S_CHK;
                    else
                        state_next = S_CR1;
                end
            end
            S_CR1:
            begin
                cmd.op = csl_pkg::OP_CR1;
                if (stat.done) state_next = S_CR2;
            end
            S_CR2:
            begin
                cmd.op = csl_pkg::OP_CR2;
                if (stat.done) state_next = S_CRCHK;
            end
            S_CRCHK:
            begin
                state_next = stat.cr_zero ? S_CHK : S_SQCX;
            end
            S_SQCX:
            begin
                cmd.op = csl_pkg::OP_SQ_CX;
                if (stat.done) state_next = S_SQCY;
            end
            S_SQCY:
            begin
                cmd.op = csl_pkg::OP_SQ_CY;
                if (stat.done) state_next = S_RTC;
            end
            S_RTC:
            begin
                cmd.op = csl_pkg::OP_RT_C;
                if (stat.done) state_next = S_AB;
            end
            S_AB:
            begin
                cmd.op = csl_pkg::OP_MUL_AB;
                if (stat.done) state_next = S_D;
            end
            S_D:
            begin
                cmd.op = csl_pkg::OP_MUL_D;
                if (stat.done) state_next = S_DCHK;
            end
            S_DCHK:
            begin
                state_next = stat.cr_ge_d ? S_SAT : S_DIVC;
            end
            S_DIVC:
            begin
                cmd.op = csl_pkg::OP_DIV_C;
                if (stat.done) state_next = S_CHK;
            end
            S_SAT:
            begin
                cmd.op     = csl_pkg::OP_SAT;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                state_next = stat.curv_le_thr ? S_TOP : S_DIVS;
            end
            S_TOP:
            begin
                cmd.op     = csl_pkg::OP_TOP;
                state_next = S_OUT;
            end
            S_DIVS:
            begin
                cmd.op = csl_pkg::OP_DIV_S;
                if (stat.done) state_next = S_RTS;
            end
            S_RTS:
            begin
                cmd.op = csl_pkg::OP_RT_S;
                if (stat.done) state_next = S_OUT;
            end
            S_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = csl_pkg::OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            S_COMMIT:
            begin
                cmd.op     = csl_pkg::OP_COMMIT;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> design/csl_dp.sv
// Datapath: point history, shared shift-add multiplier, square root and divider, result register.
module csl_dp #(
    parameter int COORD_WIDTH = csl_pkg::COORD_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  csl_pkg::cmd_t                 cmd,
    output csl_pkg::status_t              stat,
    input  logic                          in_path_start,
    input  logic signed [COORD_WIDTH-1:0] in_pos_x,
    input  logic signed [COORD_WIDTH-1:0] in_pos_y,
    input  logic [csl_pkg::CFG_W-1:0]     thr,
    input  logic [csl_pkg::CFG_W-1:0]     top,
    input  logic [csl_pkg::CFG_W-1:0]     lat,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [csl_pkg::CFG_W-1:0]     out_curvature,
    output logic [csl_pkg::CFG_W-1:0]     out_speed_limit,
    output logic [csl_pkg::ARC_W-1:0]     out_arc_length,
    output logic                          out_degenerate
);

    localparam int CW      = COORD_WIDTH;
    localparam int LW      = CW + 1;
    localparam int SQS_W   = 2 * CW + 1;
    localparam int CRW     = 2 * CW + 1;
    localparam int SCW     = 2 * CW + 2;
    localparam int ABW     = 2 * CW + 2;
    localparam int PW      = 3 * CW + 3;
    localparam int QW      = csl_pkg::RATIO_W;
    localparam int SQ_W    = (2 * CW + 2 > QW) ? 2 * CW + 2 : QW;
    localparam int SQ_H    = SQ_W / 2;
    localparam int REM_W   = SQ_H + 3;
    localparam int DRW     = PW + 1;
    localparam int MUL_IT  = CW + 1;
    localparam int MAX_A   = (MUL_IT > SQ_H) ? MUL_IT : SQ_H;
    localparam int MAX_IT  = (MAX_A > QW) ? MAX_A : QW;
    localparam int CNT_W   = $clog2(MAX_IT + 1);
    localparam int RUN_W   = ((LW > csl_pkg::ARC_W) ? LW : csl_pkg::ARC_W) + 1;
    localparam int CI      = csl_pkg::CURV_ITERS;
    localparam int CFG_W   = csl_pkg::CFG_W;

    function automatic logic signed [CW:0] sdiff(input logic signed [CW-1:0] a,
                                                 input logic signed [CW-1:0] b);
        return $signed({a[CW-1], a}) - $signed({b[CW-1], b});
    endfunction

    function automatic logic [CW-1:0] mag(input logic signed [CW:0] v);
        logic [CW:0] u;
        u = v;
        if (v[CW])
            u = ~u + 1'b1;
        return u[CW-1:0];
    endfunction

    // point history and path state
    logic signed [CW-1:0] px_reg, py_reg, h0x_reg, h0y_reg, h1x_reg, h1y_reg;
    logic [1:0]           seen_reg;
    logic [LW-1:0]        prev_seg_reg, lb_reg, lc_reg;
    logic [csl_pkg::ARC_W-1:0] run_reg;
    logic [SQS_W-1:0]     sq_reg;
    logic [2*CW-1:0]      t1_reg;
    logic                 t1_neg_reg;
    logic [CRW-1:0]       cr_reg;
    logic [ABW-1:0]       ab_reg;
    logic [PW-1:0]        d_reg;
    logic [CFG_W-1:0]     curv_reg, speed_reg;
    logic                 degen_reg;

    // iterative engine
    logic                 busy_reg, busy_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [PW-1:0]        acc_reg, acc_next, mcand_reg, mcand_next;
    logic [LW-1:0]        mplier_reg, mplier_next;
    logic                 neg_reg, neg_next;
    logic [REM_W-1:0]     rem_reg, rem_next;
    logic [SQ_H-1:0]      root_reg, root_next;
    logic [SQ_W-1:0]      rad_reg, rad_next;
    logic [DRW-1:0]       dr_reg, dr_next;
    logic [QW-1:0]        dq_reg, dq_next;
    logic [PW-1:0]        dd_reg, dd_next;
    logic                 run_eng, eng_done;

    // result register
    logic                 ov_reg;
    logic [CFG_W-1:0]     o_curv_reg, o_speed_reg;
    logic [csl_pkg::ARC_W-1:0] o_arc_reg;
    logic                 o_degen_reg;

    logic signed [CW:0]   d_a, d_b;
    logic [CW-1:0]        op_a, op_b;
    logic                 op_neg;
    logic [REM_W-1:0]     sq_cur, sq_trial;
    logic                 sq_ge;
    logic [DRW-1:0]       dv_sh;
    logic                 dv_ge;
    logic signed [SCW-1:0] s1, s2, sd;
    logic [SCW-1:0]       sd_abs;
    logic [RUN_W-1:0]     run_sum;
    logic                 same01, same12, same02;
    logic                 commit;

    assign run_eng  = csl_pkg::is_iter(cmd.op);
    assign eng_done = run_eng && busy_reg && (cnt_reg == CNT_W'(1));

    // multiplier operand selection
    always_comb
    begin
        d_a    = '0;
        d_b    = '0;
        op_neg = 1'b0;
        unique case (cmd.op)
            csl_pkg::OP_SQ_BX: begin d_a = sdiff(px_reg, h1x_reg); d_b = d_a; end
            csl_pkg::OP_SQ_BY: begin d_a = sdiff(py_reg, h1y_reg); d_b = d_a; end
            csl_pkg::OP_SQ_CX: begin d_a = sdiff(px_reg, h0x_reg); d_b = d_a; end
            csl_pkg::OP_SQ_CY: begin d_a = sdiff(py_reg, h0y_reg); d_b = d_a; end
            csl_pkg::OP_CR1:
            begin
                d_a    = sdiff(h1x_reg, h0x_reg);
                d_b    = sdiff(py_reg, h0y_reg);
                op_neg = d_a[CW] ^ d_b[CW];
            end
            csl_pkg::OP_CR2:
            begin
                d_a    = sdiff(h1y_reg, h0y_reg);
                d_b    = sdiff(px_reg, h0x_reg);
                op_neg = d_a[CW] ^ d_b[CW];
            end
            default: ;
        endcase
        op_a = mag(d_a);
        op_b = mag(d_b);
    end

    always_comb
    begin
        sq_cur   = {rem_reg[REM_W-3:0], rad_reg[SQ_W-1 -: 2]};
        sq_trial = REM_W'({root_reg, 2'b01});
        sq_ge    = (sq_cur >= sq_trial);
        dv_sh    = {dr_reg[DRW-2:0], dq_reg[QW-1]};
        dv_ge    = (dv_sh >= {1'b0, dd_reg});
    end

    // engine next state
    always_comb
    begin
        busy_next   = busy_reg;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        neg_next    = neg_reg;
        rem_next    = rem_reg;
        root_next   = root_reg;
        rad_next    = rad_reg;
        dr_next     = dr_reg;
        dq_next     = dq_reg;
        dd_next     = dd_reg;
        if (run_eng && !busy_reg)
        begin
            busy_next = 1'b1;
            unique case (cmd.op)
                csl_pkg::OP_SQ_BX, csl_pkg::OP_SQ_BY, csl_pkg::OP_SQ_CX, csl_pkg::OP_SQ_CY,
                csl_pkg::OP_CR1, csl_pkg::OP_CR2:
                begin
                    cnt_next    = CNT_W'(MUL_IT);
                    mcand_next  = PW'(op_a);
                    mplier_next = LW'(op_b);
                    neg_next    = op_neg;
                    acc_next    = (cmd.op == csl_pkg::OP_SQ_BY || cmd.op == csl_pkg::OP_SQ_CY)
                                  ? PW'(sq_reg) : '0;
                end
                csl_pkg::OP_MUL_AB:
                begin
                    cnt_next    = CNT_W'(MUL_IT);
                    mcand_next  = PW'(prev_seg_reg);
                    mplier_next = lb_reg;
                    acc_next    = '0;
                end
                csl_pkg::OP_MUL_D:
                begin
                    cnt_next    = CNT_W'(MUL_IT);
                    mcand_next  = PW'(ab_reg);
                    mplier_next = lc_reg;
                    acc_next    = '0;
                end
                csl_pkg::OP_RT_B, csl_pkg::OP_RT_C, csl_pkg::OP_RT_S:
                begin
                    cnt_next  = CNT_W'(SQ_H);
                    rem_next  = '0;
                    root_next = '0;
                    rad_next  = (cmd.op == csl_pkg::OP_RT_S) ? SQ_W'(dq_reg) : SQ_W'(sq_reg);
                end
                csl_pkg::OP_DIV_C:
                begin
                    cnt_next = CNT_W'(CI);
                    dr_next  = DRW'(cr_reg);
                    dq_next  = '0;
                    dd_next  = d_reg;
                end
                csl_pkg::OP_DIV_S:
                begin
                    cnt_next = CNT_W'(QW);
                    dr_next  = '0;
                    dq_next  = QW'({lat, 32'd0});
                    dd_next  = PW'(curv_reg);
                end
                default: ;
            endcase
        end
        else if (run_eng)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
                busy_next = 1'b0;
            unique case (cmd.op)
                csl_pkg::OP_RT_B, csl_pkg::OP_RT_C, csl_pkg::OP_RT_S:
                begin
                    rem_next  = sq_ge ? sq_cur - sq_trial : sq_cur;
                    root_next = {root_reg[SQ_H-2:0], sq_ge};
                    rad_next  = {rad_reg[SQ_W-3:0], 2'b00};
                end
                csl_pkg::OP_DIV_C, csl_pkg::OP_DIV_S:
                begin
                    dr_next = dv_ge ? dv_sh - {1'b0, dd_reg} : dv_sh;
                    dq_next = {dq_reg[QW-2:0], dv_ge};
                end
                default:
                begin
                    acc_next    = acc_reg + (mplier_reg[0] ? mcand_reg : '0);
                    mcand_next  = {mcand_reg[PW-2:0], 1'b0};
                    mplier_next = {1'b0, mplier_reg[LW-1:1]};
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else
            busy_reg <= busy_next;
    end

    always_ff @(posedge clk)
    begin
        cnt_reg    <= cnt_next;
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        neg_reg    <= neg_next;
        rem_reg    <= rem_next;
        root_reg   <= root_next;
        rad_reg    <= rad_next;
        dr_reg     <= dr_next;
        dq_reg     <= dq_next;
        dd_reg     <= dd_next;
    end

    // signed cross product from the two magnitudes
    always_comb
    begin
        s1 = $signed(SCW'(t1_reg));
        if (t1_neg_reg)
            s1 = -s1;
        s2 = $signed(SCW'(acc_next[2*CW-1:0]));
        if (neg_reg)
            s2 = -s2;
        sd     = s1 - s2;
        sd_abs = sd[SCW-1] ? -sd : sd;
    end

    assign same01  = (h0x_reg == h1x_reg) && (h0y_reg == h1y_reg);
    assign same12  = (h1x_reg == in_pos_x) && (h1y_reg == in_pos_y);
    assign same02  = (h0x_reg == in_pos_x) && (h0y_reg == in_pos_y);
    assign run_sum = RUN_W'(run_reg) + RUN_W'(lb_reg);
    assign commit  = (cmd.op == csl_pkg::OP_EMIT) || (cmd.op == csl_pkg::OP_COMMIT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seen_reg <= 2'd0;
        else if (cmd.op == csl_pkg::OP_LOAD && stat.restart)
            seen_reg <= 2'd1;
        else if (commit)
            seen_reg <= 2'd2;
    end

    always_ff @(posedge clk)
    begin
        if (eng_done)
        begin
            unique case (cmd.op)
                csl_pkg::OP_SQ_BX, csl_pkg::OP_SQ_BY, csl_pkg::OP_SQ_CX, csl_pkg::OP_SQ_CY:
                    sq_reg <= acc_next[SQS_W-1:0];
                csl_pkg::OP_CR1:
                begin
                    t1_reg     <= acc_next[2*CW-1:0];
                    t1_neg_reg <= neg_reg;
                end
                csl_pkg::OP_CR2:   cr_reg <= sd_abs[CRW-1:0];
                csl_pkg::OP_RT_B:  lb_reg <= root_next[LW-1:0];
                csl_pkg::OP_RT_C:  lc_reg <= root_next[LW-1:0];
                csl_pkg::OP_MUL_AB: ab_reg <= acc_next[ABW-1:0];
                csl_pkg::OP_MUL_D: d_reg  <= acc_next;
                csl_pkg::OP_DIV_C:
                    curv_reg <= (dq_next[CI-1:CFG_W] != '0) ? csl_pkg::CFG_MAX
                                                            : dq_next[CFG_W-1:0];
                csl_pkg::OP_RT_S:
                    speed_reg <= (root_next[SQ_H-1:CFG_W] != '0) ? csl_pkg::CFG_MAX
                                                                 : root_next[CFG_W-1:0];
                default: ;
            endcase
        end
        unique case (cmd.op)
            csl_pkg::OP_LOAD:
            begin
                if (stat.restart)
                begin
                    h0x_reg      <= in_pos_x;
                    h0y_reg      <= in_pos_y;
                    h1x_reg      <= in_pos_x;
                    h1y_reg      <= in_pos_y;
                    prev_seg_reg <= '0;
                    run_reg      <= '0;
                end
                else
                begin
                    px_reg    <= in_pos_x;
                    py_reg    <= in_pos_y;
                    curv_reg  <= '0;
                    degen_reg <= same01 || same12 || same02;
                end
            end
            csl_pkg::OP_SAT: curv_reg  <= csl_pkg::CFG_MAX;
            csl_pkg::OP_TOP: speed_reg <= top;
            csl_pkg::OP_EMIT, csl_pkg::OP_COMMIT:
            begin
                run_reg      <= (run_sum[RUN_W-1:csl_pkg::ARC_W] != '0) ? '1
                                : run_sum[csl_pkg::ARC_W-1:0];
                prev_seg_reg <= lb_reg;
                h0x_reg      <= h1x_reg;
                h0y_reg      <= h1y_reg;
                h1x_reg      <= px_reg;
                h1y_reg      <= py_reg;
            end
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (cmd.op == csl_pkg::OP_EMIT)
            ov_reg <= 1'b1;
        else if (out_ready)
            ov_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == csl_pkg::OP_EMIT)
        begin
            o_curv_reg  <= curv_reg;
            o_speed_reg <= speed_reg;
            o_arc_reg   <= run_reg;
            o_degen_reg <= degen_reg;
        end
    end

    assign out_valid       = ov_reg;
    assign out_curvature   = o_curv_reg;
    assign out_speed_limit = o_speed_reg;
    assign out_arc_length  = o_arc_reg;
    assign out_degenerate  = o_degen_reg;

    always_comb
    begin
        stat.done        = eng_done;
        stat.restart     = in_path_start || (seen_reg == 2'd0);
        stat.seen2       = (seen_reg == 2'd2);
        stat.degen       = degen_reg;
        stat.cr_zero     = (cr_reg == '0);
        stat.cr_ge_d     = (PW'(cr_reg) >= d_reg);
        stat.curv_le_thr = (curv_reg <= thr);
        stat.out_free    = !ov_reg || out_ready;
    end

endmodule

>>> design/curvature_speed_limit.sv
// Top level: curvature and speed limit along a path of points.
//
//  channel   | direction | transaction
//  ----------+-----------+--------------------------------------------------
//  in_ch     | sink      | path_start, pos_x, pos_y (one path point)
//  out_ch    | source    | curvature, speed_limit, arc_length, degenerate
//  apb       | slave     | curvature_threshold, top_speed, lateral_accel
//
// One point at a time. A path start is only recorded; the second point and
// each interior point run on the shared radix-2 multiply / square root /
// divide engine. A result waits in the output register; the next point is
// taken meanwhile, and the following result holds the controller until the
// register drains. rst_n clears history.
module curvature_speed_limit #(
    parameter int COORD_WIDTH = csl_pkg::COORD_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    csl_point_if.sink                   in_ch,
    csl_result_if.source                out_ch,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [csl_pkg::ADDR_W-1:0]  paddr,
    input  logic [csl_pkg::DATA_W-1:0]  pwdata,
    output logic [csl_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    logic [csl_pkg::CFG_W-1:0] thr, top, lat;
    csl_pkg::cmd_t             cmd;
    csl_pkg::status_t          stat;

    csl_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .thr     (thr),
        .top     (top),
        .lat     (lat)
    );

    csl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    csl_dp #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .in_path_start   (in_ch.path_start),
        .in_pos_x        (in_ch.pos_x),
        .in_pos_y        (in_ch.pos_y),
        .thr             (thr),
        .top             (top),
        .lat             (lat),
        .out_ready       (out_ch.ready),
        .out_valid       (out_ch.valid),
        .out_curvature   (out_ch.curvature),
        .out_speed_limit (out_ch.speed_limit),
        .out_arc_length  (out_ch.arc_length),
        .out_degenerate  (out_ch.degenerate)
    );

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready && !stat.restart |=> !in_ch.ready)
        else $error("point taken while a computation is running");

    a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_ch.valid) |-> $past(cmd.op == csl_pkg::OP_EMIT))
        else $error("result appeared without an emit command");

    a_done_only_iter: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done |-> csl_pkg::is_iter(cmd.op))
        else $error("engine done outside an iterative operation");

    a_emit_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == csl_pkg::OP_EMIT |-> stat.out_free)
        else $error("result register overwritten");
`endif

endmodule

>>> tb/sv/tb_curvature_speed_limit.sv
// Testbench for curvature_speed_limit: random paths checked against a scoreboard predictor.
module tb_curvature_speed_limit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW         = csl_pkg::COORD_WIDTH_DEF;
    localparam int CFG_W      = csl_pkg::CFG_W;
    localparam int ARC_W      = csl_pkg::ARC_W;
    localparam int ADDR_W     = csl_pkg::ADDR_W;
    localparam int DATA_W     = csl_pkg::DATA_W;
    localparam int WDOG_LIMIT = 20000;
    localparam int HOLD_LEN   = 3000;
    localparam int TAIL_WAIT  = 600;
    localparam logic [1:0] REG_NONE = 2'd3;

    typedef logic [191:0] wide_t;

    typedef struct {
        logic [CFG_W-1:0] curvature;
        logic [CFG_W-1:0] speed_limit;
        logic [ARC_W-1:0] arc_length;
        logic             degenerate;
    } bend_t;

    class bend_scoreboard;
        logic [CFG_W-1:0] thr, top, lat;
        wide_t            hx[2], hy[2];
        int               seen;
        logic [31:0]      run_len;
        bend_t            pending[$];
        int               errors;

        function new();
            thr = csl_pkg::THR_RST; top = csl_pkg::TOP_RST; lat = csl_pkg::LAT_RST;
            seen = 0; run_len = '0; errors = 0;
        endfunction

        function void set_reg(input logic [1:0] idx, input logic [CFG_W-1:0] v);
            case (idx)
                csl_pkg::REG_THR: thr = v;
                csl_pkg::REG_TOP: top = v;
                csl_pkg::REG_LAT: lat = v;
                default: ;
            endcase
        endfunction

        function logic [63:0] root(input wide_t v);
            logic [63:0] r;
            wide_t       c;
            r = 0;
            for (int b = 62; b >= 0; b--) begin
                c = {128'd0, r | (64'd1 << b)};
                if (c * c <= v) r = c[63:0];
            end
            return r;
        endfunction

        function logic [63:0] seg_len(input wide_t ax, ay, bx, by);
            wide_t dx, dy;
            dx = bx - ax;
            dy = by - ay;
            return root(dx * dx + dy * dy);
        endfunction

        function void note_point(input logic ps, input logic signed [CW-1:0] x, y);
            wide_t       px, py, ux, uy, vx, vy, cr, d, q, ratio;
            logic [63:0] seg, s;
            bend_t       r;
            px = wide_t'($signed(x));
            py = wide_t'($signed(y));
            if (ps || seen == 0) begin
                hx[0] = px; hy[0] = py; hx[1] = px; hy[1] = py;
                seen = 1; run_len = '0;
                return;
            end
            seg = seg_len(hx[1], hy[1], px, py);
            if (seen >= 2) begin
                r.curvature = '0;
                r.degenerate = 1'b0;
                if ((hx[0] == hx[1] && hy[0] == hy[1]) || (hx[1] == px && hy[1] == py)
                    || (hx[0] == px && hy[0] == py)) begin
                    r.degenerate = 1'b1;
                end else begin
                    ux = hx[1] - hx[0]; uy = hy[1] - hy[0];
                    vx = px - hx[0];    vy = py - hy[0];
                    cr = ux * vy - uy * vx;
                    if (cr[191]) cr = -cr;
                    if (cr != 0) begin
                        d = wide_t'(seg_len(hx[0], hy[0], hx[1], hy[1])) * wide_t'(seg)
                            * wide_t'(seg_len(hx[0], hy[0], px, py));
                        if (cr >= d) q = wide_t'(csl_pkg::CFG_MAX);
                        else q = (cr << 33) / d;
                        r.curvature = (q > 24'hFFFFFF) ? 24'hFFFFFF : q[23:0];
                    end
                end
                if (r.curvature <= thr) begin
                    r.speed_limit = top;
                end else begin
                    ratio = (wide_t'(lat) << 32) / r.curvature;
                    s = root(ratio);
                    r.speed_limit = (s > 24'hFFFFFF) ? 24'hFFFFFF : s[23:0];
                end
                r.arc_length = run_len;
                pending = {pending, r};
            end
            if (seg > 64'hFFFFFFFF) seg = 64'hFFFFFFFF;
            run_len = ({32'd0, run_len} + seg > 64'hFFFFFFFF) ? 32'hFFFFFFFF
                                                               : run_len + seg[31:0];
            hx[0] = hx[1]; hy[0] = hy[1]; hx[1] = px; hy[1] = py;
            seen = 2;
        endfunction

        function void check_result(input bend_t got);
            bend_t exp_r;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result transaction");
                return;
            end
            exp_r = pending.pop_front();
            if (got.curvature !== exp_r.curvature || got.speed_limit !== exp_r.speed_limit ||
                got.arc_length !== exp_r.arc_length || got.degenerate !== exp_r.degenerate) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch exp curv=%h spd=%h arc=%h deg=%b got %h %h %h %b",
                             exp_r.curvature, exp_r.speed_limit, exp_r.arc_length,
                             exp_r.degenerate, got.curvature, got.speed_limit,
                             got.arc_length, got.degenerate);
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [ADDR_W-1:0] paddr = 0;
    logic [DATA_W-1:0] pwdata = 0;
    logic [DATA_W-1:0] prdata;
    logic pready;

    csl_point_if  in_ch();
    csl_result_if out_ch();

    curvature_speed_limit DUT (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 clk = ~clk;

    bend_scoreboard sb = new();
    bit idle_on = 1;
    bit hold_req = 0;
    int quiet = 0;

    initial begin
        in_ch.valid = 0; in_ch.path_start = 0; in_ch.pos_x = 0; in_ch.pos_y = 0;
        out_ch.ready = 0;
    end

    always @(posedge clk) begin
        bend_t r;
        if (in_ch.valid && in_ch.ready)
            sb.note_point(in_ch.path_start, in_ch.pos_x, in_ch.pos_y);
        if (out_ch.valid && out_ch.ready) begin
            r.curvature = out_ch.curvature; r.speed_limit = out_ch.speed_limit;
            r.arc_length = out_ch.arc_length; r.degenerate = out_ch.degenerate;
            sb.check_result(r);
        end
        if (rst_n && !(in_ch.valid && in_ch.ready) && !(out_ch.valid && out_ch.ready))
            quiet++;
        else
            quiet = 0;
        if (quiet >= WDOG_LIMIT) begin
            $display("[curvature_speed_limit] ERROR");
            $finish;
        end
    end

    // receiver: random stalls, one long hold-off on request
    initial begin
        @(posedge rst_n);
        forever begin
            if (hold_req) begin
                hold_req = 0;
                out_ch.ready <= 1'b0;
                repeat (HOLD_LEN) @(posedge clk);
            end else if (idle_on && $urandom_range(0, 2) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clk);
        end
    end

    task automatic send_point(input logic ps, input logic [CW-1:0] x, y);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.path_start <= ps;
        in_ch.pos_x <= x;
        in_ch.pos_y <= y;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    task automatic apb_write(input logic [ADDR_W-1:0] a, input logic [DATA_W-1:0] v);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= a; pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (a[1:0] == 2'd0) sb.set_reg(a[3:2], v[CFG_W-1:0]);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (TAIL_WAIT) @(posedge clk);
    endtask

    task automatic set_regs(input logic [CFG_W-1:0] t, s, l);
        apb_write({csl_pkg::REG_THR, 2'b00}, {8'd0, t});
        apb_write({csl_pkg::REG_TOP, 2'b00}, {8'd0, s});
        apb_write({csl_pkg::REG_LAT, 2'b00}, {8'd0, l});
    endtask

    task automatic random_paths(input int n);
        int  cnt, plen, mode, k;
        int  bx, by, sx, sy, step;
        logic [CW-1:0] x, y, px, py;
        cnt = 0;
        while (cnt < n) begin
            plen = $urandom_range(3, 20);
            mode = $urandom_range(0, 9);
            step = 1 << $urandom_range(4, 22);
            bx = $urandom_range(0, 1 << 28) - (1 << 27);
            by = $urandom_range(0, 1 << 28) - (1 << 27);
            px = 0; py = 0;
            for (k = 0; k < plen && cnt < n; k++) begin
                if (mode == 0) begin
                    x = $urandom; y = $urandom;
                end else begin
                    sx = $urandom_range(0, step) - step / 2;
                    sy = $urandom_range(0, step) - step / 2;
                    case ($urandom_range(0, 15))
                        0: begin sx = 0; sy = 0; end
                        1: sy = 0;
                        2: sx = 0;
                        default: ;
                    endcase
                    bx += sx; by += sy;
                    x = bx; y = by;
                end
                if (k > 0 && $urandom_range(0, 40) == 0) begin x = px; y = py; end
                send_point((k == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 60) == 0),
                           x, y);
                px = x; py = y;
                cnt++;
            end
        end
    endtask

    localparam logic [CW-1:0] MINC = 32'h80000000;
    localparam logic [CW-1:0] MAXC = 32'h7FFFFFFF;
    localparam logic [CW-1:0] ONE  = 32'h00010000;

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: first point after reset, collinear, coincident, sharp, huge, restart
        send_point(1'b0, '0, '0);
        send_point(1'b0, ONE, '0);
        send_point(1'b0, 2 * ONE, '0);
        send_point(1'b0, 2 * ONE, '0);
        send_point(1'b0, 2 * ONE, ONE);
        send_point(1'b0, ONE, ONE);
        send_point(1'b0, 2 * ONE, ONE);
        send_point(1'b0, 2 * ONE, ONE + 1);
        send_point(1'b0, 2 * ONE + 1, ONE);
        send_point(1'b1, MINC, MINC);
        send_point(1'b0, MAXC, MAXC);
        send_point(1'b0, MINC, MAXC);
        send_point(1'b0, MAXC, MINC);
        send_point(1'b0, MINC, MINC);
        send_point(1'b0, MAXC, MAXC);
        send_point(1'b1, '0, '0);
        send_point(1'b0, 32'hFFFFFFFF, '0);
        send_point(1'b0, '0, '0);
        send_point(1'b0, 5 * ONE, 3 * ONE);
        send_point(1'b0, 10 * ONE, '0);
        random_paths(150);
        drain();

        set_regs(24'd0, csl_pkg::CFG_MAX, csl_pkg::CFG_MAX);
        apb_write({REG_NONE, 2'b00}, 32'h00ABCDEF);
        hold_req = 1;
        random_paths(170);
        drain();

        set_regs(csl_pkg::CFG_MAX, 24'd0, 24'd0);
        random_paths(150);
        drain();

        set_regs(CFG_W'($urandom_range(0, 200000)), CFG_W'($urandom), CFG_W'($urandom));
        random_paths(170);
        drain();

        set_regs(csl_pkg::THR_RST, csl_pkg::TOP_RST, csl_pkg::LAT_RST);
        idle_on = 0;
        random_paths(190);
        drain();

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("[curvature_speed_limit] OK");
        else
            $display("[curvature_speed_limit] ERROR");
        $finish;
    end
endmodule

>>> sim.f
design/csl_pkg.sv
design/csl_if.sv
design/csl_regs.sv
design/csl_ctrl.sv
design/csl_dp.sv
design/curvature_speed_limit.sv
tb/sv/tb_curvature_speed_limit.sv
